[hdl/ldlt_pkg.sv]
`default_nettype none
package ldlt_pkg;

  localparam int MAX_DIM  = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 72;
  localparam int FRAC_W   = 16;
  localparam int DNUM_W   = 49;
  localparam int DCNT_W   = 6;

  typedef enum logic [1:0] {
    OP_FACTOR = 2'd0,
    OP_RHS    = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_LD,
    S_TERM_RD,
    S_TERM_MUL,
    S_TERM_ACC,
    S_SUM_WR,
    S_DIAG_RD,
    S_DIAG_CHK,
    S_DIAG_WAIT,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] frow;
    logic [IDX_W-1:0] fcol;
    logic [IDX_W-1:0] sidx;
    logic [IDX_W-1:0] vidx;
    logic             acc_ld_work;
    logic             acc_ld_scaled;
    logic             mul_en;
    logic             acc_sub;
    logic             sol_wr;
    logic             scl_wr;
    logic             scl_zero;
    logic             div_start;
    logic             piv_clr;
    logic             piv_set;
    logic             out_load;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/ldlt_triangular_solve_unit.sv]
// Load items (factor or right-hand-side writes) are taken only in idle, where in_ready stays high.
// A solve of n unknowns runs forward, diagonal, backward and output passes: each product
// term is read, multiplied and accumulated, each row sum is read, loaded and written per pass,
// each nonzero diagonal is checked and then divided by a restoring divider (a zero one skips it),
// and each result is read and loaded into the output register, waiting out any output stall.
// Results come from one output register; a new result is loaded when it is empty or being taken.
// Synchronous active-low reset clears control state; stored factors and vectors are not cleared.
`default_nettype none
module ldlt_triangular_solve_unit
  import ldlt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_operation,
  input  wire logic [IDX_W-1:0]        in_row_index,
  input  wire logic [IDX_W-1:0]        in_column_index,
  input  wire logic signed [VAL_W-1:0] in_entry_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [IDX_W-1:0]             out_solution_index,
  output logic signed [VAL_W-1:0]      out_solution_value,
  output logic                         out_last_element,
  output logic                         out_zero_pivot
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ldlt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ldlt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_fire            (in_valid && in_ready),
    .in_operation       (in_operation),
    .in_row_index       (in_row_index),
    .in_column_index    (in_column_index),
    .in_entry_value     (in_entry_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_solution_index (out_solution_index),
    .out_solution_value (out_solution_value),
    .out_last_element   (out_last_element),
    .out_zero_pivot     (out_zero_pivot)
  );

endmodule
`default_nettype wire

[hdl/ldlt_div.sv]
`default_nettype none
module ldlt_div
  import ldlt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] num_in,
  input  wire logic [VAL_W-1:0] den_in,
  output logic                  done,
  output logic [VAL_W-1:0]      quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DNUM_W-1:0] num_r, num_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;

  logic [VAL_W-1:0]  s_mag, d_mag;
  logic [VAL_W:0]    trial;

  assign s_mag = num_in[VAL_W-1] ? (~num_in + 1'b1) : num_in;
  assign d_mag = den_in[VAL_W-1] ? (~den_in + 1'b1) : den_in;
  assign trial = {rem_r, num_r[DNUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // half divisor added up front gives round to nearest, ties away
      num_nxt  = {1'b0, s_mag, {FRAC_W{1'b0}}} + DNUM_W'(d_mag >> 1);
      rem_nxt  = '0;
      den_nxt  = d_mag;
      neg_nxt  = num_in[VAL_W-1] ^ den_in[VAL_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = VAL_W'(trial - {1'b0, den_r});
        num_nxt = {num_r[DNUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VAL_W-1:0];
        num_nxt = {num_r[DNUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DNUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (num_r[DNUM_W-1:VAL_W-1] != '0) begin
      quot = neg_r ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      quot = neg_r ? (~num_r[VAL_W-1:0] + 1'b1) : num_r[VAL_W-1:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

[hdl/ldlt_dp.sv]
`default_nettype none
module ldlt_dp
  import ldlt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_fire,
  input  wire logic [1:0]              in_operation,
  input  wire logic [IDX_W-1:0]        in_row_index,
  input  wire logic [IDX_W-1:0]        in_column_index,
  input  wire logic signed [VAL_W-1:0] in_entry_value,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_solution_index,
  output logic signed [VAL_W-1:0]      out_solution_value,
  output logic                         out_last_element,
  output logic                         out_zero_pivot
);

  logic [VAL_W-1:0] fmem [MAX_DIM*MAX_DIM];
  logic [VAL_W-1:0] wmem [MAX_DIM];
  logic [VAL_W-1:0] tmem [MAX_DIM];
  logic [VAL_W-1:0] smem [MAX_DIM];

  logic [VAL_W-1:0]  frd_r, wrd_r, trd_r, srd_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic              piv_r;
  logic              ovld_r;
  logic [IDX_W-1:0]  oidx_r;
  logic [VAL_W-1:0]  oval_r;
  logic              olast_r, opiv_r;

  logic [ACC_W-1:0]       acc_rnd;
  logic [ACC_W-FRAC_W-1:0] acc_sh;
  logic [VAL_W-1:0]       sum_sat;
  logic                   div_done;
  logic [VAL_W-1:0]       div_q;
  op_t                    op;

  assign op = op_t'(in_operation);

  always_ff @(posedge clk) begin
    if (in_fire && op == OP_FACTOR) begin
      fmem[{in_row_index, in_column_index}] <= in_entry_value;
    end
    if (in_fire && op == OP_RHS) begin
      wmem[in_row_index] <= in_entry_value;
    end
    if (cmd.scl_wr) begin
      tmem[cmd.vidx] <= cmd.scl_zero ? '0 : div_q;
    end
    if (cmd.sol_wr) begin
      smem[cmd.vidx] <= sum_sat;
    end
    frd_r <= fmem[{cmd.frow, cmd.fcol}];
    wrd_r <= wmem[cmd.vidx];
    trd_r <= tmem[cmd.vidx];
    srd_r <= smem[cmd.sidx];
  end

  // round half up at bit 15, then clamp to 32 bits
  assign acc_rnd = acc_r + ACC_W'(32768);
  assign acc_sh  = acc_rnd[ACC_W-1:FRAC_W];

  always_comb begin
    if (acc_sh[ACC_W-FRAC_W-1:VAL_W-1] == '0 ||
        acc_sh[ACC_W-FRAC_W-1:VAL_W-1] == '1) begin
      sum_sat = acc_sh[VAL_W-1:0];
    end else if (acc_sh[ACC_W-FRAC_W-1]) begin
      sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'($signed(frd_r) * $signed(srd_r));
    end
    if (cmd.acc_ld_work) begin
      acc_r <= {{(ACC_W-VAL_W-FRAC_W){wrd_r[VAL_W-1]}}, wrd_r, {FRAC_W{1'b0}}};
    end else if (cmd.acc_ld_scaled) begin
      acc_r <= {{(ACC_W-VAL_W-FRAC_W){trd_r[VAL_W-1]}}, trd_r, {FRAC_W{1'b0}}};
    end else if (cmd.acc_sub) begin
      acc_r <= acc_r - {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  ldlt_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num_in (srd_r),
    .den_in (frd_r),
    .done   (div_done),
    .quot   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piv_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (cmd.piv_clr) begin
        piv_r <= 1'b0;
      end else if (cmd.piv_set) begin
        piv_r <= 1'b1;
      end
      if (cmd.out_load) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      oidx_r  <= cmd.vidx;
      oval_r  <= srd_r;
      olast_r <= cmd.out_last;
      opiv_r  <= piv_r;
    end
  end

  assign stat.d_zero   = (frd_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !ovld_r || out_ready;

  assign out_valid          = ovld_r;
  assign out_solution_index = oidx_r;
  assign out_solution_value = oval_r;
  assign out_last_element   = olast_r;
  assign out_zero_pivot     = opiv_r;

endmodule
`default_nettype wire

[hdl/ldlt_ctrl.sv]
`default_nettype none
module ldlt_ctrl
  import ldlt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_operation,
  output logic                  in_ready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] dim_r;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] y_r, y_nxt;
  logic [CNT_W-1:0] x_r, x_nxt;
  logic             bwd_r, bwd_nxt;
  logic             more;
  logic             start;
  logic             y_end;

  assign start = in_valid && state_r == S_IDLE && op_t'(in_operation) == OP_SOLVE;
  assign more  = bwd_r ? (x_r < n_r) : (x_r < y_r);
  assign y_end = (y_r == n_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    y_nxt     = y_r;
    x_nxt     = x_r;
    bwd_nxt   = bwd_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (dim_r == '0) begin
            n_nxt = CNT_W'(1);
          end else if (dim_r > CNT_W'(MAX_DIM)) begin
            n_nxt = CNT_W'(MAX_DIM);
          end else begin
            n_nxt = dim_r;
          end
          y_nxt     = '0;
          bwd_nxt   = 1'b0;
          state_nxt = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        x_nxt     = bwd_r ? y_r + 1'b1 : '0;
        state_nxt = S_SUM_LD;
      end
      S_SUM_LD: state_nxt = more ? S_TERM_RD : S_SUM_WR;
      S_TERM_RD: state_nxt = S_TERM_MUL;
      S_TERM_MUL: begin
        x_nxt     = x_r + 1'b1;
        state_nxt = S_TERM_ACC;
      end
      S_TERM_ACC: state_nxt = more ? S_TERM_RD : S_SUM_WR;
      S_SUM_WR: begin
        if (!bwd_r) begin
          if (y_end) begin
            y_nxt     = '0;
            state_nxt = S_DIAG_RD;
          end else begin
            y_nxt     = y_r + 1'b1;
            state_nxt = S_SUM_RD;
          end
        end else if (y_r == '0) begin
          state_nxt = S_OUT_RD;
        end else begin
          y_nxt     = y_r - 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_DIAG_RD: state_nxt = S_DIAG_CHK;
      S_DIAG_CHK, S_DIAG_WAIT: begin
        if (state_r == S_DIAG_CHK && !stat.d_zero) begin
          state_nxt = S_DIAG_WAIT;
        end else if (state_r == S_DIAG_CHK || stat.div_done) begin
          if (y_end) begin
            bwd_nxt   = 1'b1;
            state_nxt = S_SUM_RD;
          end else begin
            y_nxt     = y_r + 1'b1;
            state_nxt = S_DIAG_RD;
          end
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        if (stat.out_free) begin
          if (y_end) begin
            state_nxt = S_IDLE;
          end else begin
            y_nxt     = y_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.frow = (state_r == S_TERM_RD && bwd_r) ? x_r[IDX_W-1:0] : y_r[IDX_W-1:0];
    cmd.fcol = (state_r == S_TERM_RD && !bwd_r) ? x_r[IDX_W-1:0] : y_r[IDX_W-1:0];
    cmd.sidx = (state_r == S_TERM_RD) ? x_r[IDX_W-1:0] : y_r[IDX_W-1:0];
    cmd.vidx = y_r[IDX_W-1:0];
    case (state_r)
      S_IDLE:     cmd.piv_clr = start;
      S_SUM_LD: begin
        cmd.acc_ld_work   = !bwd_r;
        cmd.acc_ld_scaled = bwd_r;
      end
      S_TERM_MUL: cmd.mul_en  = 1'b1;
      S_TERM_ACC: cmd.acc_sub = 1'b1;
      S_SUM_WR:   cmd.sol_wr  = 1'b1;
      S_DIAG_CHK: begin
        cmd.div_start = !stat.d_zero;
        cmd.scl_wr    = stat.d_zero;
        cmd.scl_zero  = stat.d_zero;
        cmd.piv_set   = stat.d_zero;
      end
      S_DIAG_WAIT: cmd.scl_wr = stat.div_done;
      S_OUT_LD: begin
        cmd.out_load = stat.out_free;
        cmd.out_last = y_end;
      end
      default: cmd.piv_clr = 1'b0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dim_r   <= CNT_W'(MAX_DIM);
      n_r     <= CNT_W'(MAX_DIM);
      y_r     <= '0;
      x_r     <= '0;
      bwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        dim_r <= cfg_wdata;
      end
      n_r   <= n_nxt;
      y_r   <= y_nxt;
      x_r   <= x_nxt;
      bwd_r <= bwd_nxt;
    end
  end

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIAG_WAIT)
    else $error("divider started without waiting for it");
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIAG_WAIT && !stat.div_done) |=> state_r == S_DIAG_WAIT)
    else $error("left divider wait early");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> y_r < n_r)
    else $error("row counter beyond dimension");

endmodule
`default_nettype wire

[bench/tb_ldlt_triangular_solve_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_ldlt_triangular_solve_unit;
  import ldlt_pkg::*;

  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } load_item_t;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    last;
    logic                    pivot;
  } solution_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [IDX_W-1:0] in_row_index = '0;
  logic [IDX_W-1:0] in_column_index = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_solution_index;
  logic signed [VAL_W-1:0] out_solution_value;
  logic out_last_element;
  logic out_zero_pivot;

  ldlt_triangular_solve_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_row_index       (in_row_index),
    .in_column_index    (in_column_index),
    .in_entry_value     (in_entry_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_solution_index (out_solution_index),
    .out_solution_value (out_solution_value),
    .out_last_element   (out_last_element),
    .out_zero_pivot     (out_zero_pivot)
  );

  always #4 clk = ~clk;

  load_item_t pending_items[$];
  solution_t  expected_solutions[$];
  load_item_t driven_item;

  // predictor state
  logic signed [VAL_W-1:0] factor_mem [0:MAX_DIM*MAX_DIM-1];
  logic signed [VAL_W-1:0] rhs_mem [0:MAX_DIM-1];
  logic [CNT_W-1:0] dim_setting = 7'd64;

  // stimulus side: which entries have been queued for writing so far
  bit factor_known [0:MAX_DIM*MAX_DIM-1];
  bit rhs_known [0:MAX_DIM-1];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  calm = 1'b0;

  function automatic logic signed [VAL_W-1:0] round_sat(logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + 128'sd32768) >>> FRAC_W;
    if (r > 128'sd2147483647) return 32'sh7fffffff;
    if (r < -128'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] scaled_div(logic signed [VAL_W-1:0] s,
                                                         logic signed [VAL_W-1:0] d);
    longint sl, dl;
    longint unsigned num, den, q;
    logic signed [127:0] v;
    sl = s;
    dl = d;
    num = longint'(sl < 0 ? -sl : sl) << FRAC_W;
    den = dl < 0 ? -dl : dl;
    q = (num + den / 2) / den;
    v = {64'd0, q};
    if ((sl < 0) != (dl < 0)) v = -v;
    // reuse saturation: pre-shift so round_sat is an identity apart from clamping
    return round_sat(v <<< FRAC_W);
  endfunction

  function automatic void predict_solve();
    int n;
    logic signed [VAL_W-1:0] sol [0:MAX_DIM-1];
    logic signed [VAL_W-1:0] scl [0:MAX_DIM-1];
    logic signed [127:0] acc;
    longint prod;
    bit pivot;
    solution_t s;
    n = dim_setting;
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    pivot = 1'b0;
    for (int y = 0; y < n; y++) begin
      acc = rhs_mem[y];
      acc = acc <<< FRAC_W;
      for (int x = 0; x < y; x++) begin
        prod = longint'(factor_mem[y*MAX_DIM+x]) * longint'(sol[x]);
        acc = acc - prod;
      end
      sol[y] = round_sat(acc);
    end
    for (int y = 0; y < n; y++) begin
      if (factor_mem[y*MAX_DIM+y] == 0) begin
        scl[y] = '0;
        pivot = 1'b1;
      end else begin
        scl[y] = scaled_div(sol[y], factor_mem[y*MAX_DIM+y]);
      end
    end
    for (int y = n - 1; y >= 0; y--) begin
      acc = scl[y];
      acc = acc <<< FRAC_W;
      for (int x = y + 1; x < n; x++) begin
        prod = longint'(factor_mem[x*MAX_DIM+y]) * longint'(sol[x]);
        acc = acc - prod;
      end
      sol[y] = round_sat(acc);
    end
    for (int y = 0; y < n; y++) begin
      s.idx = IDX_W'(y);
      s.val = sol[y];
      s.last = (y == n - 1);
      s.pivot = pivot;
      expected_solutions.push_back(s);
    end
  endfunction

  function automatic void apply_item(load_item_t it);
    case (it.op)
      OP_FACTOR: factor_mem[it.row*MAX_DIM+it.col] = it.val;
      OP_RHS:    rhs_mem[it.row] = it.val;
      OP_SOLVE:  predict_solve();
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_item(driven_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_operation <= driven_item.op;
          in_row_index <= driven_item.row;
          in_column_index <= driven_item.col;
          in_entry_value <= driven_item.val;
          if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 4);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    solution_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_solutions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: idx %0d val %0d", out_solution_index,
                     out_solution_value);
        end else begin
          e = expected_solutions.pop_front();
          if (out_solution_index !== e.idx || out_solution_value !== e.val ||
              out_last_element !== e.last || out_zero_pivot !== e.pivot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx %0d val %0d last %0b piv %0b, got %0d %0d %0b %0b",
                       e.idx, e.val, e.last, e.pivot, out_solution_index,
                       out_solution_value, out_last_element, out_zero_pivot);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) recv_stall <= $urandom_range(1, 4);
      end
    end
  end

  // watchdog: cycles without any item moved
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'(int'($urandom_range(0, 8)) - 4) <<< FRAC_W;
      default: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_diag();
    if ($urandom_range(0, 11) == 0) return '0;
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'(int'($urandom_range(1 << 14, 1 << 18))) * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  function automatic void add_item(op_t op, int row, int col, logic [VAL_W-1:0] val);
    load_item_t it;
    it.op = op;
    it.row = IDX_W'(row);
    it.col = IDX_W'(col);
    it.val = val;
    pending_items.push_back(it);
    if (op == OP_FACTOR) factor_known[row*MAX_DIM+col] = 1'b1;
    if (op == OP_RHS) rhs_known[row] = 1'b1;
  endfunction

  // a solve must never read an entry that was never written
  function automatic void add_solve();
    int n;
    n = dim_setting;
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    for (int y = 0; y < n; y++) begin
      if (!rhs_known[y]) add_item(OP_RHS, y, $urandom_range(0, 63), rand_value());
      for (int x = 0; x < y; x++)
        if (!factor_known[y*MAX_DIM+x]) add_item(OP_FACTOR, y, x, rand_value());
      if (!factor_known[y*MAX_DIM+y]) add_item(OP_FACTOR, y, y, rand_diag());
    end
    add_item(OP_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_solutions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(int v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    dim_setting = CNT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int dim, int count);
    int r, c;
    set_dimension(dim);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1, 2: add_item(OP_FACTOR, r, $urandom_range(0, r), rand_value());
        3:       add_item(OP_FACTOR, r, c, rand_value());
        4:       add_item(OP_FACTOR, r % 8, r % 8, rand_diag());
        5, 6:    add_item(OP_RHS, r, c, rand_value());
        7:       add_item(OP_NONE, r, c, $urandom);
        default: add_solve();
      endcase
    end
    add_solve();
  endtask

  initial begin
    for (int i = 0; i < MAX_DIM*MAX_DIM; i++) factor_mem[i] = '0;
    for (int i = 0; i < MAX_DIM; i++) rhs_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small well-conditioned system, then extremes
    set_dimension(3);
    add_item(OP_FACTOR, 0, 0, 32'sh00020000);
    add_item(OP_FACTOR, 1, 0, 32'sh00008000);
    add_item(OP_FACTOR, 1, 1, 32'shfffd0000);
    add_item(OP_FACTOR, 2, 0, 32'shffff0000);
    add_item(OP_FACTOR, 2, 1, 32'sh00018000);
    add_item(OP_FACTOR, 2, 2, 32'sh00010000);
    add_item(OP_FACTOR, 0, 2, 32'sh7fffffff); // above diagonal, unused
    add_item(OP_RHS, 0, 0, 32'sh00010000);
    add_item(OP_RHS, 1, 63, 32'sh80000000);
    add_item(OP_RHS, 2, 0, 32'sh7fffffff);
    add_item(OP_NONE, 63, 63, 32'hffffffff);
    add_solve();
    add_item(OP_FACTOR, 1, 1, '0);            // zero diagonal
    add_solve();
    add_item(OP_FACTOR, 1, 1, 32'sh00000001); // tiny divisor saturates
    add_solve();
    set_dimension(1);
    add_item(OP_FACTOR, 63, 63, 32'sh80000000);
    add_item(OP_RHS, 63, 0, 32'sh7fffffff);
    add_solve();
    set_dimension(0);
    add_solve();

    // random: small systems
    for (int p = 0; p < 6; p++)
      random_phase($urandom_range(1, 8), 10);
    // hold off the sender until every result is back
    wait_drained();
    calm = 1'b1;
    random_phase($urandom_range(2, 6), 10);

    wait_drained();
    if (mismatches == 0 && expected_solutions.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
